// ===== sv/spcp_pkg.sv =====
// Shared types, codes and helpers for the serial pixel command parser.
package spcp_pkg;

  // Parser mode, one-hot coded
  typedef enum logic [3:0] {
    MODE_IDLE   = 4'b0001,
    MODE_BRIGHT = 4'b0010,
    MODE_POS    = 4'b0100,
    MODE_DATA   = 4'b1000
  } mode_e;

  // Result kind, carried on the master-side tuser
  typedef enum logic [1:0] {
    KIND_WRITE     = 2'd0,
    KIND_SHOW      = 2'd1,
    KIND_CLEAR     = 2'd2,
    KIND_SIGNATURE = 2'd3
  } kind_e;

  // Command characters
  localparam logic [7:0] ChClear     = 8'h21;  // '!'
  localparam logic [7:0] ChSignature = 8'h3F;  // '?'
  localparam logic [7:0] ChBright    = 8'h2A;  // '*'
  localparam logic [7:0] ChPosition  = 8'h2B;  // '+'
  localparam logic [7:0] ChData      = 8'h3A;  // ':'
  localparam logic [7:0] ChEnd       = 8'h3B;  // ';'

  localparam logic [7:0] PosNone         = 8'd255;
  localparam logic [7:0] ResetBrightness = 8'd30;

  // Register byte addresses
  localparam logic [2:0] AddrDefaultBrightness = 3'd0;

  // Decoded digit of a received character
  typedef struct packed {
    logic       valid;
    logic [3:0] value;
  } digit_t;

  // Decimal digit '0'..'9'
  function automatic digit_t dec_digit(input logic [7:0] ch);
    digit_t d;
    d.valid = (ch >= 8'h30) && (ch <= 8'h39);
    d.value = 4'(ch - 8'h30);
    return d;
  endfunction

  // Hex digit '0'..'9', 'a'..'f', 'A'..'F'
  function automatic digit_t hex_digit(input logic [7:0] ch);
    digit_t d;
    d.valid = 1'b0;
    d.value = 4'd0;
    if ((ch >= 8'h30) && (ch <= 8'h39)) begin
      d.valid = 1'b1;
      d.value = 4'(ch - 8'h30);
    end else if ((ch >= 8'h61) && (ch <= 8'h66)) begin
      d.valid = 1'b1;
      d.value = 4'(ch - 8'h57);
    end else if ((ch >= 8'h41) && (ch <= 8'h46)) begin
      d.valid = 1'b1;
      d.value = 4'(ch - 8'h37);
    end
    return d;
  endfunction

  // value * 10 + digit, wrapping modulo 256
  function automatic logic [7:0] dec_accum(input logic [7:0] acc, input logic [3:0] dig);
    return 8'({acc, 3'b000} + {acc, 1'b0} + {4'd0, dig});
  endfunction

endpackage

// ===== sv/serial_pixel_command_parser.sv =====
// Serial LED strip command parser: one received character in, at most one strip command out.
//
//  Channel      Ports                         Payload (low bit first)
//  -----------  ----------------------------  -----------------------------------------------
//  rx in        s_axis_tvalid/tready/tdata    tdata[7:0] rx_byte
//  command out  m_axis_tvalid/tready/tdata    tdata: pixel_index, red, green, blue, brightness
//               m_axis_tuser                  tuser[1:0] kind
//  config       APB psel/penable/pwrite/...   0x0 default_brightness[7:0]
//
// A character is registered on transfer, decoded in the next cycle, and its
// command (if any) lands in the output register; one character per cycle while
// the output register is not stalled.
// The input register absorbs one character while the output register is stalled.
// Reset clears mode, position (to "none"), latches and brightness (to 30).
module serial_pixel_command_parser #(
  parameter int PIXEL_COUNT = 64  // strip length, 1..254
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // received characters
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] rx_byte
  // strip commands
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [39:0] m_axis_tdata_o,   // [7:0] pixel_index, [15:8] red, [23:16] green,
                                        // [31:24] blue, [39:32] brightness
  output logic [1:0]  m_axis_tuser_o,   // [1:0] kind
  // configuration
  input  logic        psel_i,
  input  logic        penable_i,
  input  logic        pwrite_i,
  input  logic [2:0]  paddr_i,
  input  logic [31:0] pwdata_i,
  output logic [31:0] prdata_o,
  output logic        pready_o
);

  localparam logic [7:0] PixelCountC = 8'(PIXEL_COUNT);

  // Configuration register
  logic [7:0] default_bright_q;
  logic       cfg_write;

  assign pready_o  = 1'b1;
  assign cfg_write = psel_i && penable_i && pwrite_i &&
                     (paddr_i == spcp_pkg::AddrDefaultBrightness);
  assign prdata_o  = (paddr_i == spcp_pkg::AddrDefaultBrightness) ? {24'd0, default_bright_q}
                                                                   : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      default_bright_q <= spcp_pkg::ResetBrightness;
    end else if (cfg_write) begin
      default_bright_q <= pwdata_i[7:0];
    end
  end

  // Input register
  logic       in_valid_q;
  logic [7:0] in_byte_q;
  logic       advance;

  // Advance the held character when the output register is free or draining
  assign advance         = in_valid_q && (!m_axis_tvalid_o || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid_i && s_axis_tready_o) begin
      in_byte_q <= s_axis_tdata_i;
    end
  end

  // Parser state
  spcp_pkg::mode_e mode_q, mode_d;
  logic [7:0] pos_q, pos_d;
  logic [1:0] chan_q, chan_d;
  logic [7:0] red_q, red_d;
  logic [7:0] green_q, green_d;
  logic [7:0] bright_q, bright_d;
  logic       restart_q, restart_d;

  // Command decode
  logic            emit;
  spcp_pkg::kind_e emit_kind;
  logic [39:0]     emit_data;
  spcp_pkg::digit_t dec, hex;
  logic [7:0]      level;
  logic [7:0]      pos_base;
  logic [7:0]      bright_use;

  assign dec        = spcp_pkg::dec_digit(in_byte_q);
  assign hex        = spcp_pkg::hex_digit(in_byte_q);
  assign level      = {hex.value, hex.value};  // nibble * 17
  assign pos_base   = (pos_q == spcp_pkg::PosNone) ? 8'd0 : pos_q;
  assign bright_use = (bright_q == 8'd0) ? default_bright_q : bright_q;

  always_comb begin
    mode_d    = mode_q;
    pos_d     = pos_q;
    chan_d    = chan_q;
    red_d     = red_q;
    green_d   = green_q;
    bright_d  = bright_q;
    restart_d = restart_q;
    emit      = 1'b0;
    emit_kind = spcp_pkg::KIND_WRITE;
    emit_data = '0;

    case (in_byte_q)
      spcp_pkg::ChClear: begin
        pos_d     = spcp_pkg::PosNone;
        emit      = 1'b1;
        emit_kind = spcp_pkg::KIND_CLEAR;
      end
      spcp_pkg::ChSignature: begin
        emit      = 1'b1;
        emit_kind = spcp_pkg::KIND_SIGNATURE;
      end
      spcp_pkg::ChBright: begin
        mode_d    = spcp_pkg::MODE_BRIGHT;
        bright_d  = 8'd0;
        pos_d     = spcp_pkg::PosNone;
        restart_d = 1'b1;
      end
      spcp_pkg::ChPosition: begin
        mode_d    = spcp_pkg::MODE_POS;
        pos_d     = spcp_pkg::PosNone;
        restart_d = 1'b0;
      end
      spcp_pkg::ChData: begin
        mode_d = spcp_pkg::MODE_DATA;
        if (restart_q) begin
          pos_d = 8'd0;
        end
        chan_d = 2'd0;
      end
      spcp_pkg::ChEnd: begin
        // Show only when at least one pixel was positioned
        emit      = (pos_q != 8'd0) && (pos_q != spcp_pkg::PosNone);
        emit_kind = spcp_pkg::KIND_SHOW;
        mode_d    = spcp_pkg::MODE_IDLE;
        pos_d     = spcp_pkg::PosNone;
        chan_d    = 2'd0;
        restart_d = 1'b1;
      end
      default: begin
        unique case (mode_q)
          spcp_pkg::MODE_DATA: begin
            // Drop everything once past the strip end or for non-hex characters
            if ((pos_q < PixelCountC) && hex.valid) begin
              if (chan_q == 2'd0) begin
                red_d  = level;
                chan_d = 2'd1;
              end else if (chan_q == 2'd1) begin
                green_d = level;
                chan_d  = 2'd2;
              end else begin
                bright_d  = bright_use;
                emit      = 1'b1;
                emit_kind = spcp_pkg::KIND_WRITE;
                emit_data = {bright_use, level, green_q, red_q, pos_q};
                chan_d    = 2'd0;
                pos_d     = pos_q + 8'd1;
              end
            end
          end
          spcp_pkg::MODE_POS: begin
            if (dec.valid) begin
              pos_d = spcp_pkg::dec_accum(pos_base, dec.value);
            end
          end
          spcp_pkg::MODE_BRIGHT: begin
            if (dec.valid) begin
              bright_d = spcp_pkg::dec_accum(bright_q, dec.value);
            end
          end
          spcp_pkg::MODE_IDLE: begin
            // ignore stray characters
          end
          default: begin
            mode_d = spcp_pkg::MODE_IDLE;
          end
        endcase
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= spcp_pkg::MODE_IDLE;
      pos_q     <= spcp_pkg::PosNone;
      chan_q    <= 2'd0;
      red_q     <= 8'd0;
      green_q   <= 8'd0;
      bright_q  <= spcp_pkg::ResetBrightness;
      restart_q <= 1'b1;
    end else if (advance) begin
      mode_q    <= mode_d;
      pos_q     <= pos_d;
      chan_q    <= chan_d;
      red_q     <= red_d;
      green_q   <= green_d;
      bright_q  <= bright_d;
      restart_q <= restart_d;
    end
  end

  // Output register: load on an emitting character, clear on transfer
  logic        out_valid_q;
  logic [39:0] out_data_q;
  logic [1:0]  out_kind_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= emit;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && emit) begin
      out_data_q <= emit_data;
      out_kind_q <= emit_kind;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tuser_o  = out_kind_q;

endmodule
